@@ design/dtg_pkg.sv @@
// ----------------------------------------------------------------------------
// dtg_pkg - shared types and constants of the DTMF tone generator
// Phase format, sine ROM contents, tone steps and the command word passed
// from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package dtg_pkg;

  // Phase accumulator width (turn fraction) and sine ROM depth (power of two)
  localparam int PHASE_BITS       = 16;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int ROM_ADDR_BITS    = $clog2(SINE_TABLE_DEPTH);

  localparam int SAMPLE_BITS = 16;
  localparam int LEN_BITS    = 16;
  localparam int KEY_BITS    = 8;

  localparam logic [LEN_BITS-1:0] TONE_LENGTH_RESET = 16'd4000;

  localparam int unsigned OUT_RATE_HZ = 8000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Depths of the command queue and of the result queue
  localparam int CMD_DEPTH      = 4;
  localparam int CMD_PTR_BITS   = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_BITS   = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH      = 4;
  localparam int OUT_PTR_BITS   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS   = $clog2(OUT_DEPTH + 1);

  // Input command codes
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_t;

  typedef logic [PHASE_BITS-1:0] phase_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // Command word from front end to back end
  typedef struct packed {
    logic   is_start;   // 1: load steps, clear phases; 0: emit one sample
    logic   last;       // final sample of the tone
    phase_t low_step;
    phase_t high_step;
  } op_t;

  // Phase step for a tone: round(f * 2^PHASE_BITS / OUT_RATE_HZ)
  function automatic phase_t step_for(input int unsigned freq);
    logic [63:0] s;
    s = ((64'(freq) << PHASE_BITS) + 64'(OUT_RATE_HZ / 2)) / OUT_RATE_HZ;
    return s[PHASE_BITS-1:0];
  endfunction

  localparam phase_t STEP_697  = step_for(697);
  localparam phase_t STEP_770  = step_for(770);
  localparam phase_t STEP_852  = step_for(852);
  localparam phase_t STEP_941  = step_for(941);
  localparam phase_t STEP_1209 = step_for(1209);
  localparam phase_t STEP_1336 = step_for(1336);
  localparam phase_t STEP_1477 = step_for(1477);
  localparam phase_t STEP_1633 = step_for(1633);

  // Divide the k-th Taylor term by (2k)(2k+1)
  function automatic logic [63:0] taylor_div(input logic [63:0] t, input int k);
    case (k)
      1:       return t / 64'd6;
      2:       return t / 64'd20;
      3:       return t / 64'd42;
      4:       return t / 64'd72;
      5:       return t / 64'd110;
      6:       return t / 64'd156;
      7:       return t / 64'd210;
      8:       return t / 64'd272;
      default: return t / 64'd342;
    endcase
  endfunction

  // sin(x) in Q2.30 by a truncated Taylor series up to x^19, clamped to [0, 1]
  function automatic logic [31:0] sin_q30(input logic [63:0] x);
    logic signed [63:0] sum;
    logic [63:0]        term;
    sum  = $signed(x);
    term = x;
    for (int k = 1; k <= 9; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = taylor_div(term, k);
      if (k % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    return sum[31:0];
  endfunction

  typedef sample_t rom_t [SINE_TABLE_DEPTH];

  // Full-wave sine table in Q1.15, folded from the first quadrant
  function automatic rom_t build_rom();
    rom_t        rom;
    int unsigned num;
    int unsigned quad;
    int unsigned r;
    logic [63:0] ang;
    logic [31:0] v;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      num  = 32'(i) * 4;
      quad = num / SINE_TABLE_DEPTH;
      r    = num % SINE_TABLE_DEPTH;
      if (quad % 2 == 1) begin
        r = SINE_TABLE_DEPTH - r;
      end
      ang = (64'(r) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      v   = (sin_q30(ang) + 32'd16384) >> 15;
      if (v > 32'd32767) begin
        v = 32'd32767;
      end
      rom[i] = (quad >= 2) ? 16'(-v) : 16'(v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage

`default_nettype wire

@@ design/dtg_front.sv @@
// ----------------------------------------------------------------------------
// dtg_front - command intake and tone bookkeeping
// Accepts words, decodes keys into step pairs, counts samples of the running
// tone and queues one command word per start and per live tick.
// ----------------------------------------------------------------------------
`default_nettype none

module dtg_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_command,
  input  wire logic [dtg_pkg::KEY_BITS-1:0]  in_key,
  input  wire logic                          cfg_we,
  input  wire logic [dtg_pkg::LEN_BITS-1:0]  cfg_wdata,
  output logic                               op_push,
  output dtg_pkg::op_t                       op_data,
  input  wire logic                          op_full
);

  logic [dtg_pkg::LEN_BITS-1:0] tone_length_r;
  logic [dtg_pkg::LEN_BITS-1:0] samples_left_r, samples_left_nxt;
  logic                         active_r, active_nxt;
  logic                         accept;
  logic                         is_start;
  dtg_pkg::phase_t              row_step, col_step;

  assign in_full  = op_full;
  assign accept   = in_push && !in_full;
  assign is_start = (in_command == dtg_pkg::CMD_START);

  // Key decode: row (low) and column (high) steps
  always_comb begin
    unique case (in_key)
      "1": begin row_step = dtg_pkg::STEP_697; col_step = dtg_pkg::STEP_1209; end
      "2": begin row_step = dtg_pkg::STEP_697; col_step = dtg_pkg::STEP_1336; end
      "3": begin row_step = dtg_pkg::STEP_697; col_step = dtg_pkg::STEP_1477; end
      "A", "a": begin row_step = dtg_pkg::STEP_697; col_step = dtg_pkg::STEP_1633; end
      "4": begin row_step = dtg_pkg::STEP_770; col_step = dtg_pkg::STEP_1209; end
      "5": begin row_step = dtg_pkg::STEP_770; col_step = dtg_pkg::STEP_1336; end
      "6": begin row_step = dtg_pkg::STEP_770; col_step = dtg_pkg::STEP_1477; end
      "B", "b": begin row_step = dtg_pkg::STEP_770; col_step = dtg_pkg::STEP_1633; end
      "7": begin row_step = dtg_pkg::STEP_852; col_step = dtg_pkg::STEP_1209; end
      "8": begin row_step = dtg_pkg::STEP_852; col_step = dtg_pkg::STEP_1336; end
      "9": begin row_step = dtg_pkg::STEP_852; col_step = dtg_pkg::STEP_1477; end
      "C", "c": begin row_step = dtg_pkg::STEP_852; col_step = dtg_pkg::STEP_1633; end
      "*": begin row_step = dtg_pkg::STEP_941; col_step = dtg_pkg::STEP_1209; end
      "0": begin row_step = dtg_pkg::STEP_941; col_step = dtg_pkg::STEP_1336; end
      "#": begin row_step = dtg_pkg::STEP_941; col_step = dtg_pkg::STEP_1477; end
      default: begin row_step = dtg_pkg::STEP_941; col_step = dtg_pkg::STEP_1633; end
    endcase
  end

  always_comb begin
    samples_left_nxt  = samples_left_r;
    active_nxt        = active_r;
    op_push           = 1'b0;
    op_data.is_start  = is_start;
    op_data.last      = (samples_left_r == dtg_pkg::LEN_BITS'(1));
    op_data.low_step  = row_step;
    op_data.high_step = col_step;
    if (accept) begin
      if (is_start) begin
        samples_left_nxt = tone_length_r;
        active_nxt       = (tone_length_r != '0);
        op_push          = 1'b1;
      end else if (active_r) begin
        samples_left_nxt = samples_left_r - dtg_pkg::LEN_BITS'(1);
        active_nxt       = !op_data.last;
        op_push          = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_length_r  <= dtg_pkg::TONE_LENGTH_RESET;
      samples_left_r <= '0;
      active_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        tone_length_r <= cfg_wdata;
      end
      samples_left_r <= samples_left_nxt;
      active_r       <= active_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/dtg_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// dtg_cmd_fifo - command queue between front end and back end
// Small register FIFO of command words with full/valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dtg_cmd_fifo (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire dtg_pkg::op_t push_data,
  output logic              full,
  input  wire logic         pop,
  output dtg_pkg::op_t      pop_data,
  output logic              valid
);

  dtg_pkg::op_t                     mem_r [dtg_pkg::CMD_DEPTH];
  logic [dtg_pkg::CMD_PTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [dtg_pkg::CMD_CNT_BITS-1:0] count_r;
  logic                             do_push, do_pop;

  assign full     = (count_r == dtg_pkg::CMD_CNT_BITS'(dtg_pkg::CMD_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + dtg_pkg::CMD_PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + dtg_pkg::CMD_PTR_BITS'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + dtg_pkg::CMD_CNT_BITS'(1);
        2'b01:   count_r <= count_r - dtg_pkg::CMD_CNT_BITS'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/dtg_back.sv @@
// ----------------------------------------------------------------------------
// dtg_back - phase accumulators, sine ROM and result queue
// Executes command words: a start loads steps and clears phases, a sample
// reads both sines, averages them and queues the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module dtg_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dtg_pkg::op_t         op_data,
  input  wire logic                 op_valid,
  output logic                      op_pop,
  output logic                      out_empty,
  input  wire logic                 out_pop,
  output dtg_pkg::sample_t          out_sample,
  output logic                      out_last
);

  dtg_pkg::phase_t  low_phase_r, high_phase_r;
  dtg_pkg::phase_t  low_step_r, high_step_r;
  dtg_pkg::sample_t rom_lo_r, rom_hi_r;
  logic             s1_valid_r, s1_last_r;
  logic [dtg_pkg::ROM_ADDR_BITS-1:0] lo_addr, hi_addr;

  dtg_pkg::sample_t                 out_sample_mem_r [dtg_pkg::OUT_DEPTH];
  logic                             out_last_mem_r   [dtg_pkg::OUT_DEPTH];
  logic [dtg_pkg::OUT_PTR_BITS-1:0] out_wr_r, out_rd_r;
  logic [dtg_pkg::OUT_CNT_BITS-1:0] out_count_r;
  logic [dtg_pkg::OUT_CNT_BITS:0]   out_used;
  logic                             out_do_pop;
  logic                             do_sample;
  logic signed [dtg_pkg::SAMPLE_BITS:0] pair_sum;

  assign lo_addr = low_phase_r[dtg_pkg::PHASE_BITS-1 -: dtg_pkg::ROM_ADDR_BITS];
  assign hi_addr = high_phase_r[dtg_pkg::PHASE_BITS-1 -: dtg_pkg::ROM_ADDR_BITS];

  // Count a sample in flight as a taken slot of the result queue
  assign out_used  = {1'b0, out_count_r} + (dtg_pkg::OUT_CNT_BITS + 1)'(s1_valid_r);
  assign op_pop    = op_valid &&
                     (op_data.is_start ||
                      (out_used < (dtg_pkg::OUT_CNT_BITS + 1)'(dtg_pkg::OUT_DEPTH)));
  assign do_sample = op_pop && !op_data.is_start;

  // Phases and registered ROM reads
  always_ff @(posedge clk) begin
    if (do_sample) begin
      rom_lo_r  <= dtg_pkg::SINE_ROM[lo_addr];
      rom_hi_r  <= dtg_pkg::SINE_ROM[hi_addr];
      s1_last_r <= op_data.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_phase_r  <= '0;
      high_phase_r <= '0;
      low_step_r   <= '0;
      high_step_r  <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      s1_valid_r <= do_sample;
      if (op_pop && op_data.is_start) begin
        low_step_r   <= op_data.low_step;
        high_step_r  <= op_data.high_step;
        low_phase_r  <= '0;
        high_phase_r <= '0;
      end else if (do_sample) begin
        low_phase_r  <= low_phase_r + low_step_r;
        high_phase_r <= high_phase_r + high_step_r;
      end
    end
  end

  // Mean of the two sines, rounded toward minus infinity
  assign pair_sum = {rom_lo_r[dtg_pkg::SAMPLE_BITS-1], rom_lo_r} +
                    {rom_hi_r[dtg_pkg::SAMPLE_BITS-1], rom_hi_r};

  assign out_empty  = (out_count_r == '0);
  assign out_do_pop = out_pop && !out_empty;
  assign out_sample = out_sample_mem_r[out_rd_r];
  assign out_last   = out_last_mem_r[out_rd_r];

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_sample_mem_r[out_wr_r] <= pair_sum[dtg_pkg::SAMPLE_BITS:1];
      out_last_mem_r[out_wr_r]   <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_wr_r    <= '0;
      out_rd_r    <= '0;
      out_count_r <= '0;
    end else begin
      if (s1_valid_r) begin
        out_wr_r <= out_wr_r + dtg_pkg::OUT_PTR_BITS'(1);
      end
      if (out_do_pop) begin
        out_rd_r <= out_rd_r + dtg_pkg::OUT_PTR_BITS'(1);
      end
      case ({s1_valid_r, out_do_pop})
        2'b10:   out_count_r <= out_count_r + dtg_pkg::OUT_CNT_BITS'(1);
        2'b01:   out_count_r <= out_count_r - dtg_pkg::OUT_CNT_BITS'(1);
        default: out_count_r <= out_count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/dtmf_tone_generator.sv @@
// ----------------------------------------------------------------------------
// dtmf_tone_generator - DTMF dual-tone sample source
// Start words pick a row/column tone pair from an ASCII key; each tick word
// of a running tone yields one Q1.15 sample, the mean of two sines.
// ----------------------------------------------------------------------------
//
//  channel | ports                                    | handshake
//  --------+------------------------------------------+--------------------------
//  input   | in_command, in_key                       | in_push / in_full
//  result  | out_sample, out_last                     | out_empty / out_pop
//  config  | cfg_wdata (tone_length)                  | cfg_we, no wait
//
//  One word is taken per cycle while the command queue has room; a tick word
//  passes the command queue, the ROM read register and the result queue
//  before its sample reaches the result ports. One sine pair is read per
//  cycle, so samples flow back to back while out_pop keeps up.
//  Reset empties both queues, stops any tone and sets tone_length to 4000.
//  A full result queue stalls the back end; words enter until the command queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module dtmf_tone_generator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input channel
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic                             in_command,
  input  wire logic [dtg_pkg::KEY_BITS-1:0]     in_key,
  // Result channel
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output logic signed [dtg_pkg::SAMPLE_BITS-1:0] out_sample,
  output logic                                  out_last,
  // Configuration
  input  wire logic                             cfg_we,
  input  wire logic [dtg_pkg::LEN_BITS-1:0]     cfg_wdata
);

  dtg_pkg::op_t op_in, op_out;
  logic         op_push, op_full, op_valid, op_pop;

  // Front end: decode keys, count samples, hand off command words
  dtg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_command (in_command),
    .in_key     (in_key),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .op_push    (op_push),
    .op_data    (op_in),
    .op_full    (op_full)
  );

  // Decouple intake from sample generation
  dtg_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (op_push),
    .push_data (op_in),
    .full      (op_full),
    .pop       (op_pop),
    .pop_data  (op_out),
    .valid     (op_valid)
  );

  // Back end: advance phases, read sines, average and queue results
  dtg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_data    (op_out),
    .op_valid   (op_valid),
    .op_pop     (op_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_sample (out_sample),
    .out_last   (out_last)
  );

endmodule

`default_nettype wire
